// ===== rtl/box_mean_filter_5x5_macros.svh =====
// Assertion helpers for the 5x5 box mean filter.
// Each helper checks on the rising edge of clock and is off while reset is high.
// Define NO_ASSERTIONS to compile every helper to nothing.
`ifndef BOX_MEAN_FILTER_5X5_MACROS_SVH
`define BOX_MEAN_FILTER_5X5_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BMF5_ASSERT(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("check failed in %m");
`define BMF5_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("check failed in %m");
`define BMF5_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("check failed in %m");
`else
`define BMF5_ASSERT(label, expr)
`define BMF5_ASSERT_IMPLY(label, ante, cons)
`define BMF5_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/bmf5_pkg.sv =====
`timescale 1ns / 1ps

package bmf5_pkg;

   localparam int WIN         = 5;
   localparam int PIX_BITS    = 8;
   localparam int CFG_BITS    = 9;
   localparam int RESET_WIDTH = 256;
   localparam int ROWS_BITS   = 3;
   localparam int MEM_BITS    = (WIN - 1) * PIX_BITS;
   // a column of five pixels: at most 5 * 255
   localparam int COLSUM_BITS = 11;
   // a full window: at most 25 * 255
   localparam int SUM_BITS    = 13;
   // floor(s / 25) == (s * 5243) >> 17 for every s below 6400
   localparam int RECIP_BITS  = 13;
   localparam int RECIP_SHIFT = 17;
   localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;

   localparam logic [ROWS_BITS-1:0]  ROWS_MAX = ROWS_BITS'(WIN - 1);
   localparam logic [RECIP_BITS-1:0] RECIP    = RECIP_BITS'(5243);

   typedef logic [PIX_BITS-1:0]    pix_type;
   typedef logic [COLSUM_BITS-1:0] colsum_type;
   typedef logic [SUM_BITS-1:0]    sum_type;
   typedef logic [PROD_BITS-1:0]   prod_type;

endpackage

// ===== rtl/box_mean_filter_5x5.sv =====
`timescale 1ns / 1ps
`include "box_mean_filter_5x5_macros.svh"

// 5x5 box mean filter over a square 8-bit gray frame sent in raster order.
// Each item on req carries one pixel in req_tdata, or, with req_tuser high, a
// flush that only moves the stream on. The result for raster position p leaves
// on rsp with item p + 2*W + 2, so send 2*W + 2 flush items after the frame to
// drain it; rsp_tlast marks the mean of the final pixel. Pixels outside the
// frame count as zero and the divisor is always 25. The block takes one item
// per clock unless rsp stalls; a result leaves four register stages after its
// item: input register with line store read, column sum, window sum, divide by
// 25. The line store is one memory of MAX_WIDTH words, one word per column,
// holding the four rows above the newest one; its single read and write port
// per cycle set the one-item-per-clock rate. Write the width (1..MAX_WIDTH, 0
// acts as 1, larger acts as MAX_WIDTH) on the csr channel between frames.
module box_mean_filter_5x5
   import bmf5_pkg::*;
#(
   parameter int MAX_WIDTH = 256
) (
   input  logic                clock,
   input  logic                reset,
   // configuration: frame width
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CFG_BITS-1:0] csr_data,
   // input items
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // [7:0] pixel
   input  logic                req_tuser,   // [0] flush
   // result items
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,   // [7:0] mean
   output logic                rsp_tlast
);

   localparam int W_BITS    = $clog2(MAX_WIDTH + 1);
   localparam int ADDR_BITS = $clog2(MAX_WIDTH);
   localparam int CNT_BITS  = 2 * W_BITS;
   localparam int RST_W     = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
   localparam int RST_FRAME = RST_W * RST_W;
   localparam int RST_LAG   = 2 * RST_W + 2;

   // ---------------------------------------------------------------------
   // configuration: keep width, frame size, output lag and stream end
   // ---------------------------------------------------------------------
   logic [W_BITS-1:0]   width_ff;
   logic [CNT_BITS-1:0] frame_ff, lag_ff, end_ff;
   logic [W_BITS-1:0]   eff_w;
   logic [CNT_BITS-1:0] frame_in, lag_in;
   logic                csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   always_comb begin
      priority if (csr_data == '0) begin
         eff_w = W_BITS'(1);
      end else if (int'(csr_data) > MAX_WIDTH) begin
         eff_w = W_BITS'(MAX_WIDTH);
      end else begin
         eff_w = W_BITS'(csr_data);
      end
      frame_in = CNT_BITS'(eff_w) * CNT_BITS'(eff_w);
      lag_in   = (CNT_BITS'(eff_w) << 1) + CNT_BITS'(2);
   end

   // ---------------------------------------------------------------------
   // pipeline handshake: each stage loads when it is empty or moves on
   // ---------------------------------------------------------------------
   logic a_vld_ff, b_vld_ff, c_vld_ff, out_vld_ff;
   logic a_ready, b_ready, c_ready, d_ready;
   logic accept, a_adv;

   assign d_ready    = ~out_vld_ff | rsp_tready;
   assign c_ready    = ~c_vld_ff | d_ready;
   assign b_ready    = ~b_vld_ff | c_ready;
   assign a_ready    = ~a_vld_ff | b_ready;
   assign req_tready = a_ready;
   assign accept     = req_tvalid & a_ready;
   assign a_adv      = a_vld_ff & b_ready;

   // ---------------------------------------------------------------------
   // stream position: item count, raster column, rows seen (saturate at 4)
   // ---------------------------------------------------------------------
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [ADDR_BITS-1:0] col_ff, col_in;
   logic [ROWS_BITS-1:0] rows_ff, rows_in;
   logic [CNT_BITS:0]    count_inc;
   logic                 cnt_wrap;
   logic                 item_out, item_last;
   pix_type              item_pix;
   logic [ADDR_BITS-1:0] item_ccol;

   always_comb begin
      count_inc = (CNT_BITS + 1)'(count_ff) + (CNT_BITS + 1)'(1);
      cnt_wrap  = count_inc >= (CNT_BITS + 1)'(end_ff);
      // drop the sample for a flush and for anything past the frame end
      item_pix  = (~req_tuser && (count_ff < frame_ff)) ? req_tdata : '0;
      item_out  = (count_ff >= lag_ff) && (count_ff < end_ff);
      item_last = count_inc == (CNT_BITS + 1)'(end_ff);
      // center column lags the newest column by two, modulo the width
      priority if (width_ff == W_BITS'(1)) begin
         item_ccol = '0;
      end else if (col_ff >= ADDR_BITS'(2)) begin
         item_ccol = col_ff - ADDR_BITS'(2);
      end else begin
         item_ccol = ADDR_BITS'(W_BITS'(col_ff) + width_ff - W_BITS'(2));
      end
      count_in = count_ff;
      col_in   = col_ff;
      rows_in  = rows_ff;
      if (accept) begin
         priority if (cnt_wrap) begin
            count_in = '0;
            col_in   = '0;
            rows_in  = '0;
         end else if ((W_BITS'(col_ff) + W_BITS'(1)) >= width_ff) begin
            count_in = count_inc[CNT_BITS-1:0];
            col_in   = '0;
            rows_in  = (rows_ff == ROWS_MAX) ? rows_ff : rows_ff + ROWS_BITS'(1);
         end else begin
            count_in = count_inc[CNT_BITS-1:0];
            col_in   = col_ff + ADDR_BITS'(1);
         end
      end
   end

   // ---------------------------------------------------------------------
   // stage A: input register and line store read (with write bypass)
   // ---------------------------------------------------------------------
   logic [MEM_BITS-1:0]  line_mem [MAX_WIDTH];
   logic [MEM_BITS-1:0]  rd_raw_ff, byp_data_ff, rd_word, wr_word;
   logic                 byp_ff;
   pix_type              a_pix_ff;
   logic [ADDR_BITS-1:0] a_col_ff, a_ccol_ff;
   logic [ROWS_BITS-1:0] a_rows_ff;
   logic                 a_out_ff, a_last_ff;

   assign rd_word = byp_ff ? byp_data_ff : rd_raw_ff;
   // push the newest pixel in, age the other rows by one
   assign wr_word = {rd_word[MEM_BITS-PIX_BITS-1:0], a_pix_ff};

   always_ff @(posedge clock) begin
      if (a_adv) begin
         line_mem[a_col_ff] <= wr_word;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_raw_ff   <= line_mem[col_ff];
         byp_ff      <= a_adv && (a_col_ff == col_ff);
         byp_data_ff <= wr_word;
         a_pix_ff    <= item_pix;
         a_col_ff    <= col_ff;
         a_ccol_ff   <= item_ccol;
         a_rows_ff   <= rows_ff;
         a_out_ff    <= item_out;
         a_last_ff   <= item_last;
      end
   end

   // ---------------------------------------------------------------------
   // stage B: column sum of the newest column, shift the five column sums
   // ---------------------------------------------------------------------
   colsum_type           colsum_ff [WIN];
   colsum_type           new_colsum;
   logic [ADDR_BITS-1:0] b_ccol_ff;
   logic                 b_out_ff, b_last_ff;

   always_comb begin
      new_colsum = COLSUM_BITS'(a_pix_ff);
      for (int k = 1; k < WIN; k++) begin
         // rows above the top of the frame hold stale data: mask them
         if (a_rows_ff >= ROWS_BITS'(k)) begin
            new_colsum = new_colsum + COLSUM_BITS'(rd_word[(k-1)*PIX_BITS +: PIX_BITS]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_adv) begin
         for (int j = 0; j < WIN - 1; j++) begin
            colsum_ff[j] <= colsum_ff[j+1];
         end
         colsum_ff[WIN-1] <= new_colsum;
         b_ccol_ff        <= a_ccol_ff;
         b_out_ff         <= a_out_ff;
         b_last_ff        <= a_last_ff;
      end
   end

   // ---------------------------------------------------------------------
   // stage C: window sum over the columns that lie inside the frame
   // ---------------------------------------------------------------------
   sum_type           sum_ff, sum_in;
   logic              c_last_ff;
   logic [W_BITS:0]   col_pos;

   always_comb begin
      sum_in  = '0;
      col_pos = '0;
      for (int j = 0; j < WIN; j++) begin
         col_pos = (W_BITS + 1)'(b_ccol_ff) + (W_BITS + 1)'(j);
         if ((col_pos >= (W_BITS + 1)'(2)) &&
             (col_pos < ((W_BITS + 1)'(width_ff) + (W_BITS + 1)'(2)))) begin
            sum_in = sum_in + SUM_BITS'(colsum_ff[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (b_vld_ff && c_ready) begin
         sum_ff    <= sum_in;
         c_last_ff <= b_last_ff;
      end
   end

   // ---------------------------------------------------------------------
   // stage D: divide by 25 through the reciprocal, result register
   // ---------------------------------------------------------------------
   prod_type prod;
   pix_type  mean_ff;
   logic     last_ff;

   assign prod = PROD_BITS'(sum_ff) * PROD_BITS'(RECIP);

   always_ff @(posedge clock) begin
      if (c_vld_ff && d_ready) begin
         mean_ff <= prod[RECIP_SHIFT +: PIX_BITS];
         last_ff <= c_last_ff;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = mean_ff;
   assign rsp_tlast  = last_ff;

   // ---------------------------------------------------------------------
   // control registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= W_BITS'(RST_W);
         frame_ff   <= CNT_BITS'(RST_FRAME);
         lag_ff     <= CNT_BITS'(RST_LAG);
         end_ff     <= CNT_BITS'(RST_FRAME + RST_LAG);
         count_ff   <= '0;
         col_ff     <= '0;
         rows_ff    <= '0;
         a_vld_ff   <= 1'b0;
         b_vld_ff   <= 1'b0;
         c_vld_ff   <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            width_ff <= eff_w;
            frame_ff <= frame_in;
            lag_ff   <= lag_in;
            end_ff   <= frame_in + lag_in;
         end
         count_ff <= count_in;
         col_ff   <= col_in;
         rows_ff  <= rows_in;
         if (a_ready) begin
            a_vld_ff <= req_tvalid;
         end
         if (b_ready) begin
            b_vld_ff <= a_vld_ff;
         end
         // drop items that give no result here
         if (c_ready) begin
            c_vld_ff <= b_vld_ff & b_out_ff;
         end
         if (d_ready) begin
            out_vld_ff <= c_vld_ff;
         end
      end
   end

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------
   `BMF5_ASSERT(rows_in_range, rows_ff <= ROWS_MAX)
   `BMF5_ASSERT_NEXT(count_wraps_at_end, accept && cnt_wrap, count_ff == '0)
   `BMF5_ASSERT_NEXT(stage_a_holds, a_vld_ff && !b_ready, a_vld_ff && $stable(a_col_ff))
   `BMF5_ASSERT_IMPLY(result_from_stage_c, $rose(out_vld_ff), $past(c_vld_ff))

endmodule
